// ----- rtl/core/llca_pkg.sv -----
// Shared constants, status codes and queue status type for the line closest-approach core.
package llca_pkg;

	localparam int COORD_BITS_DEF  = 24;
	localparam int COORD_FRAC_DEF  = 12;
	localparam int PARAM_FRAC_DEF  = 16;

	// result parameters are always signed 32-bit
	localparam int PARAM_W = 32;

	localparam int LEN_THR_W  = 52;
	localparam int DEN_THR_W  = 57;
	localparam int CFG_DATA_W = 57;
	localparam int CFG_IDX_W  = 1;
	localparam int THR_RESET  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LEN_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DEN_THR = 1'b1;

	localparam int QUEUE_DEPTH  = 8;
	localparam int FRONT_STAGES = 4;
	localparam int MUL_LAT      = 4;
	localparam int DIV_LAT      = 35;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_SECOND_DEGEN = 2'd1,
		ST_FIRST_DEGEN  = 2'd2,
		ST_PARALLEL     = 2'd3
	} status_t;

	typedef struct packed {
		logic busy;
		logic full;
	} queue_stat_t;

endpackage

// ----- rtl/core/llca_mul.sv -----
// Four-stage signed multiplier built from half-width partial products.
module llca_mul #(
	parameter int AW = 52,
	parameter int BW = 52
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int PW = AW + BW;
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;

	logic [AW-1:0] ua;
	logic [BW-1:0] ub;
	logic [AW-1:0] am_s1;
	logic [BW-1:0] bm_s1;
	logic          neg_s1, neg_s2, neg_s3;
	logic [AH+BH-1:0] pp_hh_s2;
	logic [AH+BL-1:0] pp_hl_s2;
	logic [AL+BH-1:0] pp_lh_s2;
	logic [AL+BL-1:0] pp_ll_s2;
	logic [PW-1:0]    mag_s3;
	logic signed [PW-1:0] prod_s4;

	assign ua = a;
	assign ub = b;

	always_ff @(posedge clk) begin
		// magnitudes first
		am_s1  <= ua[AW-1] ? ~ua + 1'b1 : ua;
		bm_s1  <= ub[BW-1] ? ~ub + 1'b1 : ub;
		neg_s1 <= ua[AW-1] ^ ub[BW-1];

		pp_hh_s2 <= am_s1[AW-1:AL] * bm_s1[BW-1:BL];
		pp_hl_s2 <= am_s1[AW-1:AL] * bm_s1[BL-1:0];
		pp_lh_s2 <= am_s1[AL-1:0]  * bm_s1[BW-1:BL];
		pp_ll_s2 <= am_s1[AL-1:0]  * bm_s1[BL-1:0];
		neg_s2   <= neg_s1;

		mag_s3 <= (PW'(pp_hh_s2) << (AL + BL)) + (PW'(pp_hl_s2) << AL)
			+ (PW'(pp_lh_s2) << BL) + PW'(pp_ll_s2);
		neg_s3 <= neg_s2;

		prod_s4 <= neg_s3 ? ~mag_s3 + 1'b1 : mag_s3;
	end

	assign p = prod_s4;

endmodule

// ----- rtl/core/llca_div.sv -----
// Pipelined restoring divider, truncating toward zero, clamped to signed 32 bits.
module llca_div #(
	parameter int NW = 121,
	parameter int DW = 105
) (
	input  logic                                clk,
	input  logic signed [NW-1:0]                num,
	input  logic signed [DW-1:0]                den,
	output logic signed [llca_pkg::PARAM_W-1:0] quo,
	output logic                                sat
);

	localparam int QW = llca_pkg::PARAM_W;
	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] nu;
	logic [DW-1:0] du;
	logic [NW-1:0] mn_q;
	logic [DW-1:0] md_q;
	logic          neg_q;
	logic [RW-1:0] rem_q [QW+1];
	logic [DW-1:0] dv_q  [QW+1];
	logic [QW-1:0] qb_q  [QW+1];
	logic          sgn_q [QW+1];
	logic          ovf_q [QW+1];
	logic [QW-1:0] mag;
	logic [QW-1:0] quo_q;
	logic          sat_q;

	assign nu  = num;
	assign du  = den;
	assign mag = qb_q[QW];

	always_ff @(posedge clk) begin
		mn_q  <= nu[NW-1] ? ~nu + 1'b1 : nu;
		md_q  <= du[DW-1] ? ~du + 1'b1 : du;
		neg_q <= nu[NW-1] ^ du[DW-1];

		// quotient of 2^32 or more can only clamp
		ovf_q[0] <= RW'(mn_q) >= (RW'(md_q) << QW);
		rem_q[0] <= RW'(mn_q);
		dv_q[0]  <= md_q;
		qb_q[0]  <= '0;
		sgn_q[0] <= neg_q;

		// one quotient bit per stage, MSB first
		for (int k = 0; k < QW; k++) begin
			rem_q[k+1] <= (rem_q[k] >= (RW'(dv_q[k]) << (QW - 1 - k)))
				? rem_q[k] - (RW'(dv_q[k]) << (QW - 1 - k)) : rem_q[k];
			qb_q[k+1]  <= {qb_q[k][QW-2:0], rem_q[k] >= (RW'(dv_q[k]) << (QW - 1 - k))};
			dv_q[k+1]  <= dv_q[k];
			sgn_q[k+1] <= sgn_q[k];
			ovf_q[k+1] <= ovf_q[k];
		end

		if (!sgn_q[QW]) begin
			if (ovf_q[QW] || mag[QW-1]) begin
				quo_q <= {1'b0, {(QW-1){1'b1}}};
				sat_q <= 1'b1;
			end else begin
				quo_q <= mag;
				sat_q <= 1'b0;
			end
		end else begin
			if (ovf_q[QW] || (mag[QW-1] && |mag[QW-2:0])) begin
				quo_q <= {1'b1, {(QW-1){1'b0}}};
				sat_q <= 1'b1;
			end else begin
				quo_q <= ~mag + 1'b1;
				sat_q <= 1'b0;
			end
		end
	end

	assign quo = quo_q;
	assign sat = sat_q;

endmodule

// ----- rtl/core/llca_front.sv -----
// Front part: direction vectors, dot products and degenerate-line classification.
module llca_front #(
	parameter int COORD_BITS = llca_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [COORD_BITS-1:0]         p1 [3],
	input  logic signed [COORD_BITS-1:0]         p2 [3],
	input  logic signed [COORD_BITS-1:0]         p3 [3],
	input  logic signed [COORD_BITS-1:0]         p4 [3],
	input  logic [llca_pkg::LEN_THR_W-1:0]       len_thr,
	output logic                                 push_valid,
	output logic [2+5*(2*(COORD_BITS+1)+2)-1:0]  push_data
);

	localparam int DW  = COORD_BITS + 1;
	localparam int PRW = 2 * DW;
	localparam int DOT = PRW + 2;
	localparam int CW  = (DOT > llca_pkg::LEN_THR_W) ? DOT : llca_pkg::LEN_THR_W;

	typedef struct packed {
		llca_pkg::status_t      status;
		logic signed [DOT-1:0]  d1343;
		logic signed [DOT-1:0]  d4321;
		logic signed [DOT-1:0]  d1321;
		logic signed [DOT-1:0]  d4343;
		logic signed [DOT-1:0]  d2121;
	} entry_t;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0]  a21_s1 [3];
	logic signed [DW-1:0]  b43_s1 [3];
	logic signed [DW-1:0]  v13_s1 [3];
	logic signed [PRW-1:0] bb_s2 [3];
	logic signed [PRW-1:0] aa_s2 [3];
	logic signed [PRW-1:0] vb_s2 [3];
	logic signed [PRW-1:0] ba_s2 [3];
	logic signed [PRW-1:0] va_s2 [3];
	logic signed [DOT-1:0] d1343_s3, d4321_s3, d1321_s3, d4343_s3, d2121_s3;
	logic [CW-1:0] l43, l21, thr;
	entry_t entry_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a21_s1[i] <= DW'(p2[i]) - DW'(p1[i]);
			b43_s1[i] <= DW'(p4[i]) - DW'(p3[i]);
			v13_s1[i] <= DW'(p1[i]) - DW'(p3[i]);
		end
		for (int i = 0; i < 3; i++) begin
			bb_s2[i] <= PRW'(b43_s1[i]) * PRW'(b43_s1[i]);
			aa_s2[i] <= PRW'(a21_s1[i]) * PRW'(a21_s1[i]);
			vb_s2[i] <= PRW'(v13_s1[i]) * PRW'(b43_s1[i]);
			ba_s2[i] <= PRW'(b43_s1[i]) * PRW'(a21_s1[i]);
			va_s2[i] <= PRW'(v13_s1[i]) * PRW'(a21_s1[i]);
		end
		d4343_s3 <= DOT'(bb_s2[0]) + DOT'(bb_s2[1]) + DOT'(bb_s2[2]);
		d2121_s3 <= DOT'(aa_s2[0]) + DOT'(aa_s2[1]) + DOT'(aa_s2[2]);
		d1343_s3 <= DOT'(vb_s2[0]) + DOT'(vb_s2[1]) + DOT'(vb_s2[2]);
		d4321_s3 <= DOT'(ba_s2[0]) + DOT'(ba_s2[1]) + DOT'(ba_s2[2]);
		d1321_s3 <= DOT'(va_s2[0]) + DOT'(va_s2[1]) + DOT'(va_s2[2]);

		// second line checked before first; zero length degenerate at any threshold
		if (l43 == '0 || l43 < thr) begin
			entry_s4.status <= llca_pkg::ST_SECOND_DEGEN;
		end else if (l21 == '0 || l21 < thr) begin
			entry_s4.status <= llca_pkg::ST_FIRST_DEGEN;
		end else begin
			entry_s4.status <= llca_pkg::ST_OK;
		end
		entry_s4.d1343 <= d1343_s3;
		entry_s4.d4321 <= d4321_s3;
		entry_s4.d1321 <= d1321_s3;
		entry_s4.d4343 <= d4343_s3;
		entry_s4.d2121 <= d2121_s3;
	end

	// squared lengths are never negative
	assign l43 = CW'($unsigned(d4343_s3));
	assign l21 = CW'($unsigned(d2121_s3));
	assign thr = CW'(len_thr);

	assign push_valid = v_s4;
	assign push_data  = entry_s4;

endmodule

// ----- rtl/core/llca_queue.sv -----
// Short queue between front and back parts.
module llca_queue #(
	parameter int EW = 262
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  logic [EW-1:0]         push_data,
	output logic                  pop_valid,
	output logic [EW-1:0]         pop_data,
	output llca_pkg::queue_stat_t stat
);

	localparam int PTR_W    = $clog2(llca_pkg::QUEUE_DEPTH);
	localparam int BUSY_LVL = llca_pkg::QUEUE_DEPTH - llca_pkg::FRONT_STAGES - 1;

	logic [EW-1:0]    mem [llca_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             rd_valid_q;
	logic [EW-1:0]    rd_data_q;
	logic             pop;

	// back part never stalls: drain whenever something is held
	assign pop = count_q != '0;

	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (pop) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q    <= count_q + (PTR_W+1)'(push_valid) - (PTR_W+1)'(pop);
			rd_valid_q <= pop;
		end
	end

	assign pop_valid = rd_valid_q;
	assign pop_data  = rd_data_q;
	assign stat.full = count_q == (PTR_W+1)'(llca_pkg::QUEUE_DEPTH);
	assign stat.busy = count_q >= (PTR_W+1)'(BUSY_LVL);

endmodule

// ----- rtl/core/llca_back.sv -----
// Back part: denominator, parallel check, both divisions and result register.
module llca_back #(
	parameter int COORD_BITS      = llca_pkg::COORD_BITS_DEF,
	parameter int COORD_FRAC_BITS = llca_pkg::COORD_FRAC_DEF,
	parameter int PARAM_FRAC_BITS = llca_pkg::PARAM_FRAC_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pop_valid,
	input  logic [2+5*(2*(COORD_BITS+1)+2)-1:0]  pop_data,
	input  logic [llca_pkg::DEN_THR_W-1:0]       den_thr,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic signed [llca_pkg::PARAM_W-1:0]  param_first,
	output logic signed [llca_pkg::PARAM_W-1:0]  param_second,
	output logic                                 saturated
);

	localparam int QW   = llca_pkg::PARAM_W;
	localparam int DW   = COORD_BITS + 1;
	localparam int DOT  = 2 * DW + 2;
	localparam int BIGW = 2 * DOT + 1;
	localparam int NW   = BIGW + PARAM_FRAC_BITS;
	localparam int TW   = ((PARAM_FRAC_BITS > QW) ? DOT + PARAM_FRAC_BITS : DOT + QW) + 1;
	localparam int DEN_SHIFT = 4 * COORD_FRAC_BITS;
	localparam int CMPW = (BIGW > llca_pkg::DEN_THR_W) ? BIGW : llca_pkg::DEN_THR_W;
	localparam int ML   = llca_pkg::MUL_LAT;
	localparam int DL   = llca_pkg::DIV_LAT;
	localparam int BACK_STAGES = 1 + ML + 3 + DL + ML + 1 + DL + 1;

	typedef struct packed {
		llca_pkg::status_t      status;
		logic signed [DOT-1:0]  d1343;
		logic signed [DOT-1:0]  d4321;
		logic signed [DOT-1:0]  d1321;
		logic signed [DOT-1:0]  d4343;
		logic signed [DOT-1:0]  d2121;
	} entry_t;

	typedef struct packed {
		llca_pkg::status_t      status;
		logic signed [DOT-1:0]  d1343;
		logic signed [DOT-1:0]  d4321;
		logic signed [DOT-1:0]  d4343;
	} side_a_t;

	typedef struct packed {
		llca_pkg::status_t      status;
		logic signed [DOT-1:0]  d1343;
		logic signed [DOT-1:0]  d4343;
		logic signed [QW-1:0]   s;
		logic                   sat;
	} side_c_t;

	typedef struct packed {
		llca_pkg::status_t      status;
		logic signed [QW-1:0]   s;
		logic                   sat;
	} side_d_t;

	logic [BACK_STAGES-1:0] vld_q;
	entry_t  ent_q;
	side_a_t sa_q [ML];
	side_a_t sa_e1, sa_e2, sa_e3;
	side_a_t sb_q [DL];
	side_c_t sc_q [ML];
	side_d_t sd_t1;
	side_d_t sd_q [DL];

	logic signed [2*DOT-1:0] p_dd, p_xx, p_n1, p_n2;
	logic signed [BIGW-1:0]  denom_e1, numer_e1, denom_e2, numer_e2, denom_e3, numer_e3;
	logic [BIGW-1:0]         uden;
	logic [BIGW-1:0]         absden_e2;
	logic signed [QW-1:0]    s_quo, t_quo;
	logic                    s_sat, t_sat;
	logic signed [DOT+QW-1:0] p_ts;
	logic signed [TW-1:0]    tnum_t1;
	logic signed [DOT-1:0]   d4343_t1;
	logic [1:0]              status_q;
	logic signed [QW-1:0]    pf_q, ps_q;
	logic                    sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[BACK_STAGES-2:0], pop_valid};
		end
	end

	llca_mul #(.AW(DOT), .BW(DOT)) u_mul_dd (.clk, .a(ent_q.d2121), .b(ent_q.d4343), .p(p_dd));
	llca_mul #(.AW(DOT), .BW(DOT)) u_mul_xx (.clk, .a(ent_q.d4321), .b(ent_q.d4321), .p(p_xx));
	llca_mul #(.AW(DOT), .BW(DOT)) u_mul_n1 (.clk, .a(ent_q.d1343), .b(ent_q.d4321), .p(p_n1));
	llca_mul #(.AW(DOT), .BW(DOT)) u_mul_n2 (.clk, .a(ent_q.d1321), .b(ent_q.d4343), .p(p_n2));

	assign uden = denom_e1;

	always_ff @(posedge clk) begin
		ent_q <= entry_t'(pop_data);

		sa_q[0].status <= ent_q.status;
		sa_q[0].d1343  <= ent_q.d1343;
		sa_q[0].d4321  <= ent_q.d4321;
		sa_q[0].d4343  <= ent_q.d4343;
		for (int i = 1; i < ML; i++) begin
			sa_q[i] <= sa_q[i-1];
		end

		denom_e1 <= BIGW'(p_dd) - BIGW'(p_xx);
		numer_e1 <= BIGW'(p_n1) - BIGW'(p_n2);
		sa_e1    <= sa_q[ML-1];

		absden_e2 <= uden[BIGW-1] ? ~uden + 1'b1 : uden;
		denom_e2  <= denom_e1;
		numer_e2  <= numer_e1;
		sa_e2     <= sa_e1;

		// a zero denominator is parallel at any threshold
		sa_e3 <= sa_e2;
		if (sa_e2.status == llca_pkg::ST_OK && (absden_e2 == '0
				|| CMPW'(absden_e2 >> DEN_SHIFT) < CMPW'(den_thr))) begin
			sa_e3.status <= llca_pkg::ST_PARALLEL;
		end
		denom_e3 <= denom_e2;
		numer_e3 <= numer_e2;

		sb_q[0] <= sa_e3;
		for (int i = 1; i < DL; i++) begin
			sb_q[i] <= sb_q[i-1];
		end

		sc_q[0].status <= sb_q[DL-1].status;
		sc_q[0].d1343  <= sb_q[DL-1].d1343;
		sc_q[0].d4343  <= sb_q[DL-1].d4343;
		sc_q[0].s      <= s_quo;
		sc_q[0].sat    <= s_sat;
		for (int i = 1; i < ML; i++) begin
			sc_q[i] <= sc_q[i-1];
		end

		tnum_t1      <= (TW'(sc_q[ML-1].d1343) <<< PARAM_FRAC_BITS) + TW'(p_ts);
		d4343_t1     <= sc_q[ML-1].d4343;
		sd_t1.status <= sc_q[ML-1].status;
		sd_t1.s      <= sc_q[ML-1].s;
		sd_t1.sat    <= sc_q[ML-1].sat;

		sd_q[0] <= sd_t1;
		for (int i = 1; i < DL; i++) begin
			sd_q[i] <= sd_q[i-1];
		end

		// drop the parameters unless the lines were solvable
		status_q <= sd_q[DL-1].status;
		if (sd_q[DL-1].status == llca_pkg::ST_OK) begin
			pf_q  <= sd_q[DL-1].s;
			ps_q  <= t_quo;
			sat_q <= sd_q[DL-1].sat | t_sat;
		end else begin
			pf_q  <= '0;
			ps_q  <= '0;
			sat_q <= 1'b0;
		end
	end

	llca_div #(.NW(NW), .DW(BIGW)) u_div_s (
		.clk,
		.num (NW'(numer_e3) <<< PARAM_FRAC_BITS),
		.den (denom_e3),
		.quo (s_quo),
		.sat (s_sat)
	);

	llca_mul #(.AW(DOT), .BW(QW)) u_mul_t (.clk, .a(sb_q[DL-1].d4321), .b(s_quo), .p(p_ts));

	llca_div #(.NW(TW), .DW(DOT)) u_div_t (
		.clk,
		.num (tnum_t1),
		.den (d4343_t1),
		.quo (t_quo),
		.sat (t_sat)
	);

	assign done         = vld_q[BACK_STAGES-1];
	assign status       = status_q;
	assign param_first  = pf_q;
	assign param_second = ps_q;
	assign saturated    = sat_q;

endmodule

// ----- rtl/core/line_line_closest_approach_core.sv -----
// Top level of the 3D line closest-approach core.
//
// Give it two lines as four points (first line a_start..a_end, second line b_start..b_end,
// signed fixed point with COORD_FRAC_BITS fraction bits) and it returns the parameters s and t
// of the closest points, signed Q16.16 by default, with a status code and a saturation flag.
// An item is taken at every clock edge where start is high and busy is low, so a new pair of
// lines can go in every cycle. Each result shows up on the result ports for exactly one cycle
// with done high, in the order the items went in. The receiver cannot stall the core. The
// back part holds the two 35-stage restoring dividers (one quotient bit per stage) and the
// 4-stage split multipliers; the front part and the queue between them lie before it. The
// back part drains the queue every cycle, so busy rises only if the queue nears full.
// Status: 0 ok, 1 second line degenerate, 2 first line degenerate, 3 parallel, checked in
// that order; s, t and saturated are zero unless the status is ok. Write the two thresholds
// through the cfg channel while no item is in flight; cfg_ready is always high.
module line_line_closest_approach_core #(
	parameter int COORD_BITS      = llca_pkg::COORD_BITS_DEF,
	parameter int COORD_FRAC_BITS = llca_pkg::COORD_FRAC_DEF,
	parameter int PARAM_FRAC_BITS = llca_pkg::PARAM_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        a_start_x,
	input  logic signed [COORD_BITS-1:0]        a_start_y,
	input  logic signed [COORD_BITS-1:0]        a_start_z,
	input  logic signed [COORD_BITS-1:0]        a_end_x,
	input  logic signed [COORD_BITS-1:0]        a_end_y,
	input  logic signed [COORD_BITS-1:0]        a_end_z,
	input  logic signed [COORD_BITS-1:0]        b_start_x,
	input  logic signed [COORD_BITS-1:0]        b_start_y,
	input  logic signed [COORD_BITS-1:0]        b_start_z,
	input  logic signed [COORD_BITS-1:0]        b_end_x,
	input  logic signed [COORD_BITS-1:0]        b_end_y,
	input  logic signed [COORD_BITS-1:0]        b_end_z,

	output logic                                done,
	output logic [1:0]                          status,
	output logic signed [llca_pkg::PARAM_W-1:0] param_first,
	output logic signed [llca_pkg::PARAM_W-1:0] param_second,
	output logic                                saturated,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [llca_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [llca_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int DOT = 2 * (COORD_BITS + 1) + 2;
	localparam int EW  = 2 + 5 * DOT;

	logic signed [COORD_BITS-1:0] p1 [3];
	logic signed [COORD_BITS-1:0] p2 [3];
	logic signed [COORD_BITS-1:0] p3 [3];
	logic signed [COORD_BITS-1:0] p4 [3];

	logic [llca_pkg::LEN_THR_W-1:0] len_thr_q;
	logic [llca_pkg::DEN_THR_W-1:0] den_thr_q;

	logic                  in_accept;
	logic                  push_valid;
	logic [EW-1:0]         push_data;
	logic                  pop_valid;
	logic [EW-1:0]         pop_data;
	llca_pkg::queue_stat_t q_stat;

	assign p1[0] = a_start_x;
	assign p1[1] = a_start_y;
	assign p1[2] = a_start_z;
	assign p2[0] = a_end_x;
	assign p2[1] = a_end_y;
	assign p2[2] = a_end_z;
	assign p3[0] = b_start_x;
	assign p3[1] = b_start_y;
	assign p3[2] = b_start_z;
	assign p4[0] = b_end_x;
	assign p4[1] = b_end_y;
	assign p4[2] = b_end_z;

	// registers are always writable; values are masked to their widths
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_thr_q <= llca_pkg::LEN_THR_W'(llca_pkg::THR_RESET);
			den_thr_q <= llca_pkg::DEN_THR_W'(llca_pkg::THR_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				llca_pkg::REG_LEN_THR: begin
					len_thr_q <= cfg_data[llca_pkg::LEN_THR_W-1:0];
				end
				llca_pkg::REG_DEN_THR: begin
					den_thr_q <= cfg_data[llca_pkg::DEN_THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// hold off new items only while the queue could not absorb the front part's contents
	assign busy      = q_stat.busy;
	assign in_accept = start && !busy;

	llca_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk,
		.arst_n,
		.in_valid   (in_accept),
		.p1,
		.p2,
		.p3,
		.p4,
		.len_thr    (len_thr_q),
		.push_valid,
		.push_data
	);

	llca_queue #(.EW(EW)) u_queue (
		.clk,
		.arst_n,
		.push_valid,
		.push_data,
		.pop_valid,
		.pop_data,
		.stat       (q_stat)
	);

	llca_back #(
		.COORD_BITS      (COORD_BITS),
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_back (
		.clk,
		.arst_n,
		.pop_valid,
		.pop_data,
		.den_thr      (den_thr_q),
		.done,
		.status,
		.param_first,
		.param_second,
		.saturated
	);

	// a full queue must already be refusing new items
	a_full_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> busy)
		else $error("queue full while new items are still taken");

	// nothing may be pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |=> !(push_valid && $past(q_stat.full) && q_stat.full && !pop_valid))
		else $error("queue overflow");

	// a result that is not ok carries zero parameters and no saturation
	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != llca_pkg::ST_OK)
			|-> (param_first == '0 && param_second == '0 && !saturated))
		else $error("non-ok result carries parameters");

endmodule
